FILE: design/line_pixel_stepper_unit_assert.svh
// Assertion macros used by the line pixel stepper checker
`ifndef LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH
`define LINE_PIXEL_STEPPER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line pixel stepper assertion failed");

// Next-cycle implication, disabled during reset
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line pixel stepper assertion failed");

`endif

FILE: design/lps_pkg.sv
// Shared types and constants of the line pixel stepper
package lps_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int MAX_COORD_BITS = 16;
	localparam int FIELD_BITS     = 10;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [FIELD_BITS-1:0] start_x;
		logic [FIELD_BITS-1:0] start_y;
		logic [FIELD_BITS-1:0] end_x;
		logic [FIELD_BITS-1:0] end_y;
	} cmd_item_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pixel_x;
		logic [FIELD_BITS-1:0] pixel_y;
		logic                  pixel_valid;
		logic                  last_pixel;
	} res_item_t;

endpackage

FILE: design/lps_in_stage.sv
// Input register of the line pixel stepper
module lps_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  lps_pkg::cmd_item_t cmd,
	output logic              cmd_stall,
	input  logic              out_ready,
	output logic              fire,
	output lps_pkg::cmd_item_t item_s1
);

	logic valid_s1;

	// item in s1 moves on when the result register can take it
	assign fire      = valid_s1 && out_ready;
	assign cmd_stall = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

endmodule

FILE: design/lps_core.sv
// Line state and Bresenham step logic
module lps_core #(
	parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  lps_pkg::cmd_item_t item_s1,
	output lps_pkg::res_item_t res_next
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 3;
	localparam int MW = lps_pkg::MAX_COORD_BITS;
	localparam int FB = lps_pkg::FIELD_BITS;

	// line state
	logic [CB-1:0]        cur_col_q, cur_row_q, final_col_q, final_row_q;
	logic [CB-1:0]        adc_q, adr_q;
	logic signed [DW-1:0] dterm_q;
	logic                 steep_q, col_dec_q, active_q;

	logic [CB-1:0]        cur_col_d, cur_row_d, final_col_d, final_row_d;
	logic [CB-1:0]        adc_d, adr_d;
	logic signed [DW-1:0] dterm_d;
	logic                 steep_d, col_dec_d, active_d;

	// endpoints cut to COORD_BITS
	logic [MW-1:0] w_sx, w_sy, w_ex, w_ey;
	logic [CB-1:0] sx, sy, ex, ey;
	logic          swap;
	logic [CB-1:0] ox1, oy1, ox2, oy2;
	logic          ld_col_dec, ld_steep;
	logic [CB-1:0] ld_adc, ld_adr;
	logic signed [DW-1:0] ld_two_adc, ld_two_adr, ld_dterm;

	// step terms
	logic signed [DW-1:0] st_two_adc, st_two_adr;
	logic [CB-1:0]        col_stepped, row_stepped;
	logic                 dterm_neg;

	assign w_sx = MW'(item_s1.start_x);
	assign w_sy = MW'(item_s1.start_y);
	assign w_ex = MW'(item_s1.end_x);
	assign w_ey = MW'(item_s1.end_y);
	assign sx   = w_sx[CB-1:0];
	assign sy   = w_sy[CB-1:0];
	assign ex   = w_ex[CB-1:0];
	assign ey   = w_ey[CB-1:0];

	// order so the row ascends; equal rows keep the given order
	assign swap = sy > ey;
	assign ox1  = swap ? ex : sx;
	assign oy1  = swap ? ey : sy;
	assign ox2  = swap ? sx : ex;
	assign oy2  = swap ? sy : ey;

	assign ld_col_dec = ox2 < ox1;
	assign ld_adc     = ld_col_dec ? (ox1 - ox2) : (ox2 - ox1);
	assign ld_adr     = oy2 - oy1;
	assign ld_steep   = ld_adr > ld_adc;
	assign ld_two_adc = DW'({ld_adc, 1'b0});
	assign ld_two_adr = DW'({ld_adr, 1'b0});
	assign ld_dterm   = ld_steep ? (ld_two_adc - DW'(ld_adr)) : (ld_two_adr - DW'(ld_adc));

	assign st_two_adc  = DW'({adc_q, 1'b0});
	assign st_two_adr  = DW'({adr_q, 1'b0});
	assign col_stepped = col_dec_q ? (cur_col_q - CB'(1)) : (cur_col_q + CB'(1));
	assign row_stepped = cur_row_q + CB'(1);
	assign dterm_neg   = dterm_q[DW-1];

	always_comb begin
		cur_col_d   = cur_col_q;
		cur_row_d   = cur_row_q;
		final_col_d = final_col_q;
		final_row_d = final_row_q;
		adc_d       = adc_q;
		adr_d       = adr_q;
		dterm_d     = dterm_q;
		steep_d     = steep_q;
		col_dec_d   = col_dec_q;
		active_d    = active_q;
		res_next    = '0;

		unique case (item_s1.op)
			lps_pkg::OP_LOAD: begin
				cur_col_d   = ox1;
				cur_row_d   = oy1;
				final_col_d = ox2;
				final_row_d = oy2;
				adc_d       = ld_adc;
				adr_d       = ld_adr;
				dterm_d     = ld_dterm;
				steep_d     = ld_steep;
				col_dec_d   = ld_col_dec;
				active_d    = !(ox1 == ox2 && oy1 == oy2);
			end
			lps_pkg::OP_STEP: begin
				if (active_q) begin
					if (!steep_q) begin
						cur_col_d = col_stepped;
						if (dterm_neg) begin
							dterm_d = dterm_q + st_two_adr;
						end else begin
							cur_row_d = row_stepped;
							dterm_d   = dterm_q + st_two_adr - st_two_adc;
						end
					end else begin
						cur_row_d = row_stepped;
						if (dterm_neg) begin
							dterm_d = dterm_q + st_two_adc;
						end else begin
							cur_col_d = col_stepped;
							dterm_d   = dterm_q + st_two_adc - st_two_adr;
						end
					end
					active_d = !(cur_col_d == final_col_q && cur_row_d == final_row_q);
				end
			end
			default: begin
			end
		endcase

		// idle step gives an all-zero result
		if (item_s1.op == lps_pkg::OP_LOAD || active_q) begin
			res_next.pixel_x     = FB'(cur_col_d);
			res_next.pixel_y     = FB'(cur_row_d);
			res_next.pixel_valid = 1'b1;
			res_next.last_pixel  = !active_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			final_col_q <= '0;
			final_row_q <= '0;
			adc_q       <= '0;
			adr_q       <= '0;
			dterm_q     <= '0;
			steep_q     <= 1'b0;
			col_dec_q   <= 1'b0;
			active_q    <= 1'b0;
		end else if (fire) begin
			cur_col_q   <= cur_col_d;
			cur_row_q   <= cur_row_d;
			final_col_q <= final_col_d;
			final_row_q <= final_row_d;
			adc_q       <= adc_d;
			adr_q       <= adr_d;
			dterm_q     <= dterm_d;
			steep_q     <= steep_d;
			col_dec_q   <= col_dec_d;
			active_q    <= active_d;
		end
	end

endmodule

FILE: design/lps_out_stage.sv
// Result register of the line pixel stepper
module lps_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lps_pkg::res_item_t res_next,
	output logic               out_ready,
	output logic               res_valid,
	input  logic               res_stall,
	output lps_pkg::res_item_t res
);

	logic               valid_q;
	lps_pkg::res_item_t res_q;

	assign out_ready = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_next;
		end
	end

endmodule

FILE: design/line_pixel_stepper_unit.sv
// An accepted cmd passes through the input register, then the result register, before res can be
// accepted; res_valid rises as the item leaves s1, which a held result can delay.
// Throughput: one item per cycle while the result is not held; every item, load or step,
// yields exactly one result; the rate is set by the decision-term update in lps_core feeding the result register.
// A load yields the lower-row endpoint (start on equal rows); each step the next pixel, last_pixel marks the end.
// Reset (arst_n low, asynchronous): both stages empty, line idle, all line state zero.
module line_pixel_stepper_unit #(
	parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  lps_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output lps_pkg::res_item_t res
);

	// s1 holds the accepted item; it moves into the result register and
	// updates the line state in the same edge, so the next item sees it.
	logic               out_ready;
	logic               fire;
	lps_pkg::cmd_item_t item_s1;
	lps_pkg::res_item_t res_next;

	// input register; stalls only while s1 is full and the result is held
	lps_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_stall (cmd_stall),
		.out_ready (out_ready),
		.fire      (fire),
		.item_s1   (item_s1)
	);

	// endpoint ordering, axis choice and one Bresenham step
	lps_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item_s1  (item_s1),
		.res_next (res_next)
	);

	// result register; takes a new pixel whenever empty or being drained
	lps_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_next  (res_next),
		.out_ready (out_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

FILE: design/lps_checker.sv
// Port-level checks of the line pixel stepper and their binding
`include "line_pixel_stepper_unit_assert.svh"

module lps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input lps_pkg::res_item_t res
);

	`LPS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))
	`LPS_ASSERT_NOW(a_no_stall_empty, clk, arst_n, !res_valid, !cmd_stall)
	`LPS_ASSERT_NOW(a_idle_zero, clk, arst_n, res_valid && !res.pixel_valid, res.pixel_x == '0 && res.pixel_y == '0 && !res.last_pixel)
	`LPS_ASSERT_NOW(a_last_valid, clk, arst_n, res_valid && res.last_pixel, res.pixel_valid)

endmodule

bind line_pixel_stepper_unit lps_checker u_lps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

FILE: verif/line_pixel_stepper_unit_chk.sv
// Channel monitor and pixel predictor for the line pixel stepper testbench
module line_pixel_stepper_unit_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  lps_pkg::cmd_item_t cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  lps_pkg::res_item_t res,
	output int                 fail_count,
	output int                 pending
);
	import lps_pkg::*;

	localparam int CW = FIELD_BITS;
	localparam int DW = FIELD_BITS + 3;

	// traced line state
	logic [CW-1:0]        at_col, at_row, end_col, end_row;
	logic [CW-1:0]        span_col, span_row;
	logic signed [DW-1:0] err_term;
	logic                 steep, col_down, drawing;

	res_item_t pixel_queue[$];
	int        pixel_errors;

	function automatic res_item_t next_pixel(input cmd_item_t c);
		res_item_t            px;
		logic [CW-1:0]        x1, y1, x2, y2;
		logic signed [DW-1:0] sx, sy;
		px = '0;
		if (c.op == OP_LOAD) begin
			// row must not fall along the line
			if (c.start_y > c.end_y) begin
				x1 = c.end_x;
				y1 = c.end_y;
				x2 = c.start_x;
				y2 = c.start_y;
			end else begin
				x1 = c.start_x;
				y1 = c.start_y;
				x2 = c.end_x;
				y2 = c.end_y;
			end
			at_col   = x1;
			at_row   = y1;
			end_col  = x2;
			end_row  = y2;
			col_down = (x2 < x1);
			span_col = col_down ? x1 - x2 : x2 - x1;
			span_row = y2 - y1;
			steep    = (span_row > span_col);
			sx       = {{(DW - CW){1'b0}}, span_col};
			sy       = {{(DW - CW){1'b0}}, span_row};
			err_term = steep ? DW'(2 * sx - sy) : DW'(2 * sy - sx);
			drawing  = !(x1 == x2 && y1 == y2);
			px.pixel_x     = x1;
			px.pixel_y     = y1;
			px.pixel_valid = 1'b1;
			px.last_pixel  = !drawing;
		end else if (drawing) begin
			sx = {{(DW - CW){1'b0}}, span_col};
			sy = {{(DW - CW){1'b0}}, span_row};
			if (!steep) begin
				at_col = col_down ? at_col - 1'b1 : at_col + 1'b1;
				if (err_term < 0) begin
					err_term = DW'(err_term + 2 * sy);
				end else begin
					at_row   = at_row + 1'b1;
					err_term = DW'(err_term + 2 * sy - 2 * sx);
				end
			end else begin
				at_row = at_row + 1'b1;
				if (err_term < 0) begin
					err_term = DW'(err_term + 2 * sx);
				end else begin
					at_col   = col_down ? at_col - 1'b1 : at_col + 1'b1;
					err_term = DW'(err_term + 2 * sx - 2 * sy);
				end
			end
			px.pixel_x     = at_col;
			px.pixel_y     = at_row;
			px.pixel_valid = 1'b1;
			px.last_pixel  = (at_col == end_col && at_row == end_row);
			if (px.last_pixel) begin
				drawing = 1'b0;
			end
		end
		return px;
	endfunction

	task automatic flag_error(input string what);
		pixel_errors++;
		if (pixel_errors <= 10) begin
			$display("%s", what);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			pixel_queue.delete();
			at_col     = '0;
			at_row     = '0;
			end_col    = '0;
			end_row    = '0;
			span_col   = '0;
			span_row   = '0;
			err_term   = '0;
			steep      = 1'b0;
			col_down   = 1'b0;
			drawing    = 1'b0;
			pending    <= 0;
			fail_count <= pixel_errors;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				pixel_queue.push_back(next_pixel(cmd));
			end
			if (res_valid && !res_stall) begin
				if (pixel_queue.size() == 0) begin
					flag_error($sformatf("unexpected pixel x=%0d y=%0d valid=%0b last=%0b",
						res.pixel_x, res.pixel_y, res.pixel_valid, res.last_pixel));
				end else begin
					want = pixel_queue.pop_front();
					if (res.pixel_x !== want.pixel_x || res.pixel_y !== want.pixel_y ||
						res.pixel_valid !== want.pixel_valid ||
						res.last_pixel !== want.last_pixel) begin
						flag_error($sformatf(
							"pixel mismatch: want x=%0d y=%0d v=%0b l=%0b, got x=%0d y=%0d v=%0b l=%0b",
							want.pixel_x, want.pixel_y, want.pixel_valid, want.last_pixel,
							res.pixel_x, res.pixel_y, res.pixel_valid, res.last_pixel));
					end
				end
			end
			pending    <= pixel_queue.size();
			fail_count <= pixel_errors;
		end
	end

endmodule

FILE: verif/line_pixel_stepper_unit_tb.sv
// Stimulus and verdict for the line pixel stepper regression
module line_pixel_stepper_unit_tb;
	import lps_pkg::*;

	typedef logic [FIELD_BITS-1:0] coord_t;

	localparam int CMAX      = (1 << FIELD_BITS) - 1;
	localparam int ITEMS     = 400;
	localparam int LONG_HOLD = 120;     // receiver blackout, long enough to back up the pipe
	localparam int DRAIN     = 8;       // wait after the drain, leave some slack
	localparam int LIMIT     = 200000;  // far above the slowest legal run

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      res_valid;
	logic      res_stall;
	res_item_t res;

	int fail_count;
	int pending;     // pixels predicted but not yet seen
	int sent;        // items accepted by the block so far
	int cycle_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	line_pixel_stepper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	line_pixel_stepper_unit_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Hard stop in case the block hangs or drops a pixel.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Gap length: mostly back to back, some short gaps, the odd long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Windows with no gaps at all, placed on different stretches per side.
	function automatic bit tx_calm();
		return (sent % 100) < 12 || (sent >= 150 && sent < 200);
	endfunction

	function automatic bit rx_calm();
		return (sent % 100) >= 40 && (sent % 100) < 55;
	endfunction

	// Fully random item; step items carry junk coordinates the block must ignore.
	function automatic cmd_item_t any_cmd();
		cmd_item_t c;
		c.op      = op_t'($urandom_range(0, 1));
		c.start_x = coord_t'($urandom_range(0, CMAX));
		c.start_y = coord_t'($urandom_range(0, CMAX));
		c.end_x   = coord_t'($urandom_range(0, CMAX));
		c.end_y   = coord_t'($urandom_range(0, CMAX));
		return c;
	endfunction

	// Point within reach of base, clamped to the coordinate range.
	function automatic coord_t near(input coord_t base, input int reach);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
		if (v < 0) begin
			v = 0;
		end else if (v > CMAX) begin
			v = CMAX;
		end
		return v[FIELD_BITS-1:0];
	endfunction

	// Steps after the load until the final endpoint: the major axis span.
	function automatic int line_len(input coord_t x1, y1, x2, y2);
		int dx, dy;
		dx = (x1 > x2) ? int'(x1 - x2) : int'(x2 - x1);
		dy = (y1 > y2) ? int'(y1 - y2) : int'(y2 - y1);
		return (dx > dy) ? dx : dy;
	endfunction

	// Offer one item and hold it until the block takes it, then maybe idle.
	// Valid is left high when no gap follows, so back-to-back items never
	// lower and raise it in the same step.
	task automatic push_cmd(input cmd_item_t c);
		int gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		sent++;
		gap = tx_calm() ? 0 : idle_len();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Load a line, then step it; extra steps past the end hit the idle case.
	task automatic draw(input coord_t x1, y1, x2, y2, input int steps, input int extra);
		cmd_item_t c;
		c         = any_cmd();
		c.op      = OP_LOAD;
		c.start_x = x1;
		c.start_y = y1;
		c.end_x   = x2;
		c.end_y   = y2;
		push_cmd(c);
		repeat (steps + extra) begin
			c    = any_cmd();
			c.op = OP_STEP;
			push_cmd(c);
		end
	endtask

	// Drop valid and wait until every predicted pixel has come back.
	// pending is updated by nonblocking assignment, so it lags the queue.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver: random stall stretches, one long blackout while the sender
	// keeps pushing so the block fills up and stalls its input.
	initial begin
		int n;
		bit long_hold_done;
		res_stall      = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!long_hold_done && sent >= 150) begin
				long_hold_done = 1'b1;
				res_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				n = rx_calm() ? 0 : idle_len();
				res_stall <= (n != 0);
				if (n > 1) begin
					repeat (n - 1) @(posedge clk);
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		coord_t x1, y1, x2, y2;
		int     kind, len, steps, reach;
		bit     paused;
		cmd_item_t c;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		sent        = 0;
		paused      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners.
		c    = any_cmd();
		c.op = OP_STEP;
		push_cmd(c);                          // step with no line: invalid pixel
		draw(CMAX, CMAX, CMAX, CMAX, 0, 1);   // zero length at the far corner, then idle step
		draw(4, 9, 0, 9, 4, 0);               // horizontal right to left, equal rows kept
		draw(0, 0, CMAX, CMAX, 2, 0);         // full diagonal, cut off by the next load
		draw(2, CMAX, 5, 0, 2, 0);            // rows swapped, steep, column falls
		draw(CMAX, 0, 0, 1, 1, 0);            // widest shallow line, column falls
		draw(7, 3, 7, 6, 3, 1);               // vertical, then idle step
		draw(0, 0, 3, 1, 3, 0);               // shallow rising

		// Random part: mostly complete short lines, some long lines cut short,
		// some truncated lines and a little noise.
		while (sent < ITEMS) begin
			if (!paused && sent >= 300) begin
				paused = 1'b1;
				wait_drained();
			end
			kind = $urandom_range(0, 99);
			x1   = coord_t'($urandom_range(0, CMAX));
			y1   = coord_t'($urandom_range(0, CMAX));
			if (kind < 80) begin
				reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
				x2    = near(x1, reach);
				y2    = near(y1, reach);
				len   = line_len(x1, y1, x2, y2);
				draw(x1, y1, x2, y2, len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
			end else if (kind < 88) begin
				// long span: big decision term swings, abandoned part way
				x2    = coord_t'($urandom_range(0, CMAX));
				y2    = coord_t'($urandom_range(0, CMAX));
				len   = line_len(x1, y1, x2, y2);
				steps = $urandom_range(5, 30);
				draw(x1, y1, x2, y2, (steps > len) ? len : steps, 0);
			end else if (kind < 95) begin
				x2  = near(x1, 12);
				y2  = near(y1, 12);
				len = line_len(x1, y1, x2, y2);
				draw(x1, y1, x2, y2, (len == 0) ? 0 : $urandom_range(0, len - 1), 0);
			end else begin
				push_cmd(any_cmd());
			end
		end

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
